### sv/nbsa_pkg.sv
// ----------------------------------------------------------------------------
// nbsa_pkg
// Shared constants, codes and types for the named byte-set algebra block.
// ----------------------------------------------------------------------------
`default_nettype none

package nbsa_pkg;

  localparam int NUM_SETS      = 26;
  localparam int ELEMENT_CODES = 256;
  localparam int WORD_BITS     = 64;
  localparam int WORDS_PER_SET = (ELEMENT_CODES + WORD_BITS - 1) / WORD_BITS;
  localparam int MEM_DEPTH     = NUM_SETS * WORDS_PER_SET;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int SLOT_W        = $clog2(NUM_SETS);
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int WIDX_W        = 2;
  localparam int STEP_W        = $clog2(2 * WORDS_PER_SET + 1);

  localparam logic [7:0] NAME_BASE = 8'h41;

  typedef enum logic [3:0] {
    KIND_CREATE    = 4'd0,
    KIND_DELETE    = 4'd1,
    KIND_ADD       = 4'd2,
    KIND_REMOVE    = 4'd3,
    KIND_SHOW      = 4'd4,
    KIND_LIST      = 4'd5,
    KIND_UNION     = 4'd6,
    KIND_INTERSECT = 4'd7,
    KIND_DIFF      = 4'd8,
    KIND_SUBSET    = 4'd9,
    KIND_EQUAL     = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_NAME = 3'd1,
    ST_NO_SET   = 3'd2,
    ST_EXISTS   = 3'd3,
    ST_NO_ELEM  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ALU_OR,
    ALU_AND,
    ALU_ANDN,
    ALU_XOR,
    ALU_SET,
    ALU_CLR
  } alu_op_e;

  typedef struct packed {
    alu_op_e              op;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [BIT_W-1:0]     bit_idx;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] res;
    logic                 zero;
    logic                 hit;
  } alu_rsp_t;

  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [WORD_BITS-1:0] word;
    logic [WIDX_W-1:0]    idx;
    logic                 truth;
    logic                 last;
  } res_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [WIDX_W-1:0] widx);
    return ADDR_W'(slot * WORDS_PER_SET) + ADDR_W'(widx);
  endfunction

endpackage

`default_nettype wire

### sv/nbsa_ram.sv
// ----------------------------------------------------------------------------
// nbsa_ram
// Generic single-port RAM, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 104
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

### sv/nbsa_alu.sv
// ----------------------------------------------------------------------------
// nbsa_alu
// Shared bitmap unit: word combine, bit set/clear, zero and bit test flags.
// ----------------------------------------------------------------------------
`default_nettype none

module nbsa_alu import nbsa_pkg::*; (
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] res;

  always_comb begin
    mask = WORD_BITS'(1) << req_i.bit_idx;
    case (req_i.op)
      ALU_OR:   res = req_i.a | req_i.b;
      ALU_AND:  res = req_i.a & req_i.b;
      ALU_ANDN: res = req_i.a & ~req_i.b;
      ALU_XOR:  res = req_i.a ^ req_i.b;
      ALU_SET:  res = req_i.a | mask;
      ALU_CLR:  res = req_i.a & ~mask;
      default:  res = req_i.a;
    endcase
    rsp_o.res  = res;
    rsp_o.zero = (res == '0);
    rsp_o.hit  = |(req_i.a & mask);
  end

endmodule

`default_nettype wire

### sv/named_byte_set_algebra.sv
// ----------------------------------------------------------------------------
// named_byte_set_algebra
// 26 named byte sets held as 256-bit bitmaps in one RAM; a small sequencer
// drives a shared bitmap unit for create/delete/add/remove/show/list and
// union, intersection, difference, subset and equality.
//
//   channel   handshake              word fields
//   command   start / busy           kind_i first_name_i second_name_i element_i
//   result    res_valid_o (strobe)   status_o bitmap_word_o word_index_o truth_o
//                                    last_o
//
// Each command is decoded first: delete, list and errors answer from decode;
// create clears the set's four words; add/remove read one word and write it
// back; show reads four words; binary ops make eight single-port RAM reads,
// A and B words interleaved. Unknown kinds hold busy for one cycle, no result.
// busy drops as the last result is registered; the next word can be
// accepted while that result is strobed.
// Reset clears the set-exists flags; RAM words are cleared on create.
// Results cannot be stalled: each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module named_byte_set_algebra import nbsa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  kind_i,
  input  wire logic [7:0]  first_name_i,
  input  wire logic [7:0]  second_name_i,
  input  wire logic [7:0]  element_i,
  output logic             res_valid_o,
  output logic [2:0]       status_o,
  output logic [63:0]      bitmap_word_o,
  output logic [1:0]       word_index_o,
  output logic             truth_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_RMW,
    S_SHOW,
    S_BIN
  } state_e;

  state_e                state_q;
  logic [STEP_W-1:0]     step_q;
  logic [NUM_SETS-1:0]   exists_q;
  logic [3:0]            kind_q;
  logic [7:0]            a_name_q;
  logic [7:0]            b_name_q;
  logic [7:0]            elem_q;
  logic [WORD_BITS-1:0]  x_q;
  logic                  truth_q;
  res_t                  res_q;

  logic                  a_ok;
  logic                  b_ok;
  logic                  a_live;
  logic                  b_live;
  logic [SLOT_W-1:0]     a_slot;
  logic [SLOT_W-1:0]     b_slot;
  logic [WIDX_W-1:0]     elem_word;
  logic [STEP_W-1:0]     prev_step;
  logic [WIDX_W-1:0]     show_idx;
  logic [WIDX_W-1:0]     bin_rd_idx;
  logic [WIDX_W-1:0]     bin_out_idx;
  logic                  elem_oob;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  function automatic res_t mk_res(input status_e st, input logic [WORD_BITS-1:0] word,
                                  input logic [WIDX_W-1:0] idx, input logic truth,
                                  input logic last);
    res_t r;
    r.valid  = 1'b1;
    r.status = st;
    r.word   = word;
    r.idx    = idx;
    r.truth  = truth;
    r.last   = last;
    return r;
  endfunction

  // name decode
  assign a_ok   = (a_name_q >= NAME_BASE) && (9'(a_name_q) < 9'(NAME_BASE) + 9'(NUM_SETS));
  assign b_ok   = (b_name_q >= NAME_BASE) && (9'(b_name_q) < 9'(NAME_BASE) + 9'(NUM_SETS));
  assign a_slot = SLOT_W'(a_name_q - NAME_BASE);
  assign b_slot = SLOT_W'(b_name_q - NAME_BASE);
  assign a_live = a_ok && exists_q[a_slot];
  assign b_live = b_ok && exists_q[b_slot];

  assign elem_word   = WIDX_W'(elem_q >> BIT_W);
  assign elem_oob    = {1'b0, elem_q} >= 9'(ELEMENT_CODES);
  assign prev_step   = step_q - STEP_W'(1);
  assign show_idx    = WIDX_W'(prev_step);
  assign bin_rd_idx  = WIDX_W'(step_q >> 1);
  assign bin_out_idx = WIDX_W'(prev_step >> 1);

  // RAM port and shared unit steering
  always_comb begin
    ram_we          = 1'b0;
    ram_addr        = word_addr(a_slot, WIDX_W'(0));
    ram_wdata       = alu_rsp.res;
    alu_req.op      = ALU_OR;
    alu_req.a       = x_q;
    alu_req.b       = ram_rdata;
    alu_req.bit_idx = elem_q[BIT_W-1:0];
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = word_addr(a_slot, WIDX_W'(step_q));
        ram_wdata = '0;
      end
      S_RMW: begin
        ram_we     = (step_q != '0);
        ram_addr   = word_addr(a_slot, elem_word);
        alu_req.a  = ram_rdata;
        alu_req.op = (kind_q == KIND_ADD) ? ALU_SET : ALU_CLR;
      end
      S_SHOW: begin
        ram_addr = word_addr(a_slot, WIDX_W'(step_q));
      end
      S_BIN: begin
        ram_addr = word_addr(step_q[0] ? b_slot : a_slot, bin_rd_idx);
        case (kind_q)
          KIND_UNION:     alu_req.op = ALU_OR;
          KIND_INTERSECT: alu_req.op = ALU_AND;
          KIND_DIFF:      alu_req.op = ALU_ANDN;
          KIND_SUBSET:    alu_req.op = ALU_ANDN;
          KIND_EQUAL:     alu_req.op = ALU_XOR;
          default:        alu_req.op = ALU_OR;
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  nbsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  nbsa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      exists_q    <= '0;
      res_q.valid <= 1'b0;
    end else begin
      res_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q   <= kind_i;
            a_name_q <= first_name_i;
            b_name_q <= second_name_i;
            elem_q   <= element_i;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          step_q  <= '0;
          truth_q <= 1'b1;
          state_q <= S_IDLE;
          case (kind_q)
            KIND_CREATE: begin
              if (!a_ok) begin
                res_q <= mk_res(ST_BAD_NAME, '0, '0, 1'b0, 1'b1);
              end else if (exists_q[a_slot]) begin
                res_q <= mk_res(ST_EXISTS, '0, '0, 1'b0, 1'b1);
              end else begin
                exists_q[a_slot] <= 1'b1;
                state_q          <= S_CLEAR;
              end
            end
            KIND_DELETE: begin
              if (!a_live) begin
                res_q <= mk_res(ST_NO_SET, '0, '0, 1'b0, 1'b1);
              end else begin
                exists_q[a_slot] <= 1'b0;
                res_q <= mk_res(ST_OK, '0, '0, 1'b0, 1'b1);
              end
            end
            KIND_ADD, KIND_REMOVE: begin
              if (!a_live) begin
                res_q <= mk_res(ST_NO_SET, '0, '0, 1'b0, 1'b1);
              end else if (elem_oob) begin
                res_q <= mk_res((kind_q == KIND_ADD) ? ST_OK : ST_NO_ELEM,
                                '0, '0, 1'b0, 1'b1);
              end else begin
                state_q <= S_RMW;
              end
            end
            KIND_SHOW: begin
              if (!a_live) begin
                res_q <= mk_res(ST_NO_SET, '0, '0, 1'b0, 1'b1);
              end else begin
                state_q <= S_SHOW;
              end
            end
            KIND_LIST: begin
              res_q <= mk_res(ST_OK, WORD_BITS'(exists_q), '0, 1'b0, 1'b1);
            end
            KIND_UNION, KIND_INTERSECT, KIND_DIFF, KIND_SUBSET, KIND_EQUAL: begin
              if (!a_live || !b_live) begin
                res_q <= mk_res(ST_NO_SET, '0, '0, 1'b0, 1'b1);
              end else begin
                state_q <= S_BIN;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_CLEAR: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(WORDS_PER_SET - 1)) begin
            res_q   <= mk_res(ST_OK, '0, '0, 1'b0, 1'b1);
            state_q <= S_IDLE;
          end
        end
        S_RMW: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q != '0) begin
            if (kind_q == KIND_ADD || alu_rsp.hit) begin
              res_q <= mk_res(ST_OK, '0, '0, 1'b0, 1'b1);
            end else begin
              res_q <= mk_res(ST_NO_ELEM, '0, '0, 1'b0, 1'b1);
            end
            state_q <= S_IDLE;
          end
        end
        S_SHOW: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q != '0) begin
            res_q <= mk_res(ST_OK, ram_rdata, show_idx, 1'b0,
                            step_q == STEP_W'(WORDS_PER_SET));
          end
          if (step_q == STEP_W'(WORDS_PER_SET)) begin
            state_q <= S_IDLE;
          end
        end
        S_BIN: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q != '0) begin
            if (!prev_step[0]) begin
              x_q <= ram_rdata;
            end else if (kind_q == KIND_SUBSET || kind_q == KIND_EQUAL) begin
              truth_q <= truth_q & alu_rsp.zero;
              if (step_q == STEP_W'(2 * WORDS_PER_SET)) begin
                res_q <= mk_res(ST_OK, '0, '0, truth_q & alu_rsp.zero, 1'b1);
              end
            end else begin
              res_q <= mk_res(ST_OK, alu_rsp.res, bin_out_idx, 1'b0,
                              step_q == STEP_W'(2 * WORDS_PER_SET));
            end
          end
          if (step_q == STEP_W'(2 * WORDS_PER_SET)) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign res_valid_o   = res_q.valid;
  assign status_o      = res_q.status;
  assign bitmap_word_o = res_q.word;
  assign word_index_o  = res_q.idx;
  assign truth_o       = res_q.truth;
  assign last_o        = res_q.last;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

  a_idx_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && word_index_o != '0 |-> status_o == ST_OK)
    else $error("bitmap word with error status");

  a_truth_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && truth_o |-> last_o)
    else $error("truth flag on non-final result");

endmodule

`default_nettype wire
